@@ hw/rtl/rjpf_pkg.sv @@
// shared types and constants of the rtp/jpeg packet framer
package rjpf_pkg;

   // command codes carried in req_tuser
   typedef enum logic {
      CMD_HEADER  = 1'b0,
      CMD_PAYLOAD = 1'b1
   } cmd_type;

   // configuration register indexes
   localparam logic [1:0] CSR_TCP_INTERLEAVE = 2'd0;
   localparam logic [1:0] CSR_SSRC_VALUE     = 2'd1;
   localparam logic [1:0] CSR_TS_STEP        = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // reset values of the configuration registers
   localparam logic [31:0] SSRC_RESET = 32'h13F9_7E67;
   localparam logic [31:0] STEP_RESET = 32'd3600;

   // fixed header bytes
   localparam logic [7:0] INTERLEAVE_MAGIC = 8'h24;
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] RTP_PT_JPEG      = 8'h1A;
   localparam logic [7:0] RTP_MARKER       = 8'h80;
   localparam logic [7:0] JPEG_TYPE        = 8'h01;
   localparam logic [7:0] JPEG_QUALITY     = 8'hFF;

   // fixed header lengths
   localparam logic [13:0] RTP_JPEG_HDR_LEN = 14'd20;
   localparam logic [13:0] QT_HDR_LEN       = 14'd4;

   // byte positions in the longest header (interleave + rtp + jpeg + qt)
   localparam logic [4:0] POS_RTP_START  = 5'd4;
   localparam logic [4:0] POS_JPEG_END   = 5'd23;
   localparam logic [4:0] POS_QT_END     = 5'd27;

   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 8;

   // one accepted request
   typedef struct packed {
      cmd_type     command;
      logic [23:0] frag_offset;
      logic [11:0] payload_len;
      logic [11:0] tables_len;
      logic [7:0]  width_blocks;
      logic [7:0]  height_blocks;
      logic        end_of_frame;
      logic [7:0]  data_byte;
   } req_item_type;

endpackage

@@ hw/rtl/rtp_jpeg_packet_framer.sv @@
// rtp/jpeg packet framer top level: header builder, payload pass-through, output register
//
// Frames one jpeg scan fragment as an rtp/jpeg packet (rfc 2435 payload) on a byte
// stream. A header transaction (req_tuser = 0) produces the optional four-byte
// interleave header (tcp_interleave = 1), the 12-byte rtp header, the 8-byte jpeg
// header and, for fragment offset zero, the 4-byte quantisation-table header: 20 to
// 28 bytes, one per cycle while the output register is free, as the byte counter of
// the header builder walks the layout. A payload transaction (req_tuser = 1) passes
// one byte through, so payload bytes stream back to back unless the output stalls.
// Payload bytes with no packet open are dropped, not waiting on the output register.
// The last byte of a packet carries rsp_tlast; a packet with no payload ends
// on its last header byte. A new header abandons an unfinished packet, which still
// counts as sent. The sequence number increments per packet and the timestamp
// advances by timestamp_step after an end-of-frame packet. Results sit in an output
// register, so the next transaction is taken while a result still waits. Write the
// configuration registers only while the block is idle.
module rtp_jpeg_packet_framer (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // frag_offset[23:0], payload_len[35:24], tables_len[47:36],
   // width_blocks[55:48], height_blocks[63:56], data_byte[71:64]
   input  logic [rjpf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  logic                                req_tuser,
   // end_of_frame
   input  logic                                req_tlast,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_byte[7:0]
   output logic [rjpf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // packet_last
   output logic                                rsp_tlast,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rjpf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rjpf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rjpf_pkg::*;

   // configuration registers
   logic        tcp_ff;
   logic [31:0] ssrc_ff;
   logic [31:0] step_ff;

   // work stage: the transaction being turned into bytes
   logic         work_valid_ff, work_valid_in;
   req_item_type work_ff, work_in;
   logic [4:0]   idx_ff, idx_in;

   // packet state
   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic [12:0] left_ff, left_in;
   logic        open_ff, open_in;
   logic        pending_ff, pending_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   // datapath
   logic        out_free;
   logic        is_hdr;
   logic        off_zero;
   logic [12:0] body;
   logic [13:0] pkt_size;
   logic [4:0]  pos;
   logic        hdr_end;
   logic [7:0]  hdr_byte;
   logic [12:0] left_dec;
   logic        emit_hdr;
   logic        emit_pay;
   logic        work_done;
   logic        req_take;

   assign csr_ready = 1'b1;

   // configuration writes; an unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_ff  <= 1'b0;
         ssrc_ff <= SSRC_RESET;
         step_ff <= STEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TCP_INTERLEAVE: tcp_ff  <= csr_data[0];
            CSR_SSRC_VALUE:     ssrc_ff <= csr_data;
            CSR_TS_STEP:        step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // the output register frees up when it is empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_hdr   = (work_ff.command == CMD_HEADER);
   assign off_zero = (work_ff.frag_offset == 24'd0);

   // bytes after the headers, and the rtp packet length for the interleave header
   assign body     = {1'b0, work_ff.payload_len}
                   + (off_zero ? {1'b0, work_ff.tables_len} : 13'd0);
   assign pkt_size = RTP_JPEG_HDR_LEN + {1'b0, body} + (off_zero ? QT_HDR_LEN : 14'd0);

   // position in the full 28-byte layout; udp mode skips the interleave bytes
   assign pos     = tcp_ff ? idx_ff : idx_ff + POS_RTP_START;
   assign hdr_end = off_zero ? (pos == POS_QT_END) : (pos == POS_JPEG_END);

   // header byte select; sequence and timestamp bytes come after the first byte,
   // by which time an abandoned packet has already been accounted for
   always_comb begin
      unique case (pos)
         5'd0:    hdr_byte = INTERLEAVE_MAGIC;
         5'd1:    hdr_byte = 8'h00;
         5'd2:    hdr_byte = {2'b00, pkt_size[13:8]};
         5'd3:    hdr_byte = pkt_size[7:0];
         5'd4:    hdr_byte = RTP_VERSION_BYTE;
         5'd5:    hdr_byte = RTP_PT_JPEG | (work_ff.end_of_frame ? RTP_MARKER : 8'h00);
         5'd6:    hdr_byte = seq_ff[15:8];
         5'd7:    hdr_byte = seq_ff[7:0];
         5'd8:    hdr_byte = ts_ff[31:24];
         5'd9:    hdr_byte = ts_ff[23:16];
         5'd10:   hdr_byte = ts_ff[15:8];
         5'd11:   hdr_byte = ts_ff[7:0];
         5'd12:   hdr_byte = ssrc_ff[31:24];
         5'd13:   hdr_byte = ssrc_ff[23:16];
         5'd14:   hdr_byte = ssrc_ff[15:8];
         5'd15:   hdr_byte = ssrc_ff[7:0];
         5'd16:   hdr_byte = 8'h00;
         5'd17:   hdr_byte = work_ff.frag_offset[23:16];
         5'd18:   hdr_byte = work_ff.frag_offset[15:8];
         5'd19:   hdr_byte = work_ff.frag_offset[7:0];
         5'd20:   hdr_byte = JPEG_TYPE;
         5'd21:   hdr_byte = JPEG_QUALITY;
         5'd22:   hdr_byte = work_ff.width_blocks;
         5'd23:   hdr_byte = work_ff.height_blocks;
         5'd24:   hdr_byte = 8'h00;
         5'd25:   hdr_byte = 8'h00;
         5'd26:   hdr_byte = {4'h0, work_ff.tables_len[11:8]};
         5'd27:   hdr_byte = work_ff.tables_len[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   assign left_dec = left_ff - 13'd1;

   // what the work stage does this cycle
   assign emit_hdr  = work_valid_ff && is_hdr && out_free;
   assign emit_pay  = work_valid_ff && !is_hdr && open_ff && out_free;
   // a payload byte with no packet open retires at once with no result
   assign work_done = (emit_hdr && hdr_end) || emit_pay
                    || (work_valid_ff && !is_hdr && !open_ff);

   assign req_tready = !work_valid_ff || work_done;
   assign req_take   = req_tvalid && req_tready;

   // work stage next state
   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      idx_in        = idx_ff;
      if (work_done) begin
         work_valid_in = 1'b0;
         idx_in        = 5'd0;
      end else if (emit_hdr) begin
         idx_in = idx_ff + 5'd1;
      end
      if (req_take) begin
         work_valid_in         = 1'b1;
         work_in.command       = cmd_type'(req_tuser);
         work_in.frag_offset   = req_tdata[23:0];
         work_in.payload_len   = req_tdata[35:24];
         work_in.tables_len    = req_tdata[47:36];
         work_in.width_blocks  = req_tdata[55:48];
         work_in.height_blocks = req_tdata[63:56];
         work_in.data_byte     = req_tdata[71:64];
         work_in.end_of_frame  = req_tlast;
      end
   end

   // packet state next value
   always_comb begin
      seq_in     = seq_ff;
      ts_in      = ts_ff;
      left_in    = left_ff;
      open_in    = open_ff;
      pending_in = pending_ff;
      if (emit_hdr && idx_ff == 5'd0 && open_ff) begin
         // abandoned packet still counts as sent
         seq_in     = seq_ff + 16'd1;
         ts_in      = pending_ff ? ts_ff + step_ff : ts_ff;
         pending_in = 1'b0;
         open_in    = 1'b0;
         left_in    = 13'd0;
      end
      if (emit_hdr && hdr_end) begin
         if (body == 13'd0) begin
            // empty packet completes on its last header byte
            seq_in     = seq_ff + 16'd1;
            ts_in      = work_ff.end_of_frame ? ts_ff + step_ff : ts_ff;
            pending_in = 1'b0;
            open_in    = 1'b0;
            left_in    = 13'd0;
         end else begin
            pending_in = work_ff.end_of_frame;
            open_in    = 1'b1;
            left_in    = body;
         end
      end
      if (emit_pay) begin
         left_in = left_dec;
         if (left_dec == 13'd0) begin
            seq_in     = seq_ff + 16'd1;
            ts_in      = pending_ff ? ts_ff + step_ff : ts_ff;
            pending_in = 1'b0;
            open_in    = 1'b0;
         end
      end
   end

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_hdr) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hdr_byte;
         rsp_last_in  = hdr_end && (body == 13'd0);
      end else if (emit_pay) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = work_ff.data_byte;
         rsp_last_in  = (left_dec == 13'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         idx_ff        <= 5'd0;
         seq_ff        <= 16'd0;
         ts_ff         <= 32'd0;
         left_ff       <= 13'd0;
         open_ff       <= 1'b0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         idx_ff        <= idx_in;
         seq_ff        <= seq_in;
         ts_ff         <= ts_in;
         left_ff       <= left_in;
         open_ff       <= open_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // an open packet always has payload bytes outstanding
   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (left_ff != 13'd0))
      else $error("packet open with no bytes left");

   // the sequence number only ever steps by one
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(seq_ff) |-> (seq_ff == 16'($past(seq_ff) + 16'd1)))
      else $error("sequence number jumped");

   // the header counter never runs past the end of the header
   a_hdr_bound: assert property (@(posedge clock) disable iff (reset)
      (work_valid_ff && is_hdr) |-> (pos <= POS_QT_END))
      else $error("header byte counter out of range");

   // a last payload byte closes the packet
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (emit_pay && left_dec == 13'd0) |=> !open_ff)
      else $error("packet still open after its last byte");
`endif

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the rtp/jpeg packet framer
`timescale 1ns / 100ps

module testbench;
   import rjpf_pkg::*;

   // cycles with no transaction on any channel before the run is given up
   localparam int QUIET_LIMIT = 5000;
   // cycles allowed after the last expected octet before the registers are touched
   localparam int SETTLE_CYCLES = 40;
   // least number of requests per random phase that actually produce octets
   localparam int PHASE_REQS = 52;
   // index beyond the register file, writes to it must be ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // where the expectation of a request comes from
   typedef enum logic [1:0] {
      BY_MODEL,
      TYPED_BYTE,
      TYPED_NONE
   } check_mode_type;

   // one octet on the response stream
   typedef struct packed {
      logic [7:0] octet;
      logic       last;
   } wire_octet_type;

   // one directed request with its expectation where it is obvious
   typedef struct packed {
      check_mode_type mode;
      req_item_type   req;
      logic [7:0]     octet;
      logic           last;
   } directed_row_type;

   localparam int N_DIRECTED = 14;

   // directed requests, all under the reset register values
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // stray payload byte straight after reset: dropped
      '{TYPED_NONE, '{CMD_PAYLOAD, 24'h0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b0, 8'h11},
        8'h00, 1'b0},
      // first fragment with tables, smallest width and largest height, ends the frame
      '{BY_MODEL, '{CMD_HEADER, 24'h0, 12'd2, 12'd1, 8'h00, 8'hFF, 1'b1, 8'h00},
        8'h00, 1'b0},
      '{TYPED_BYTE, '{CMD_PAYLOAD, 24'h0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b0, 8'h00},
        8'h00, 1'b0},
      '{TYPED_BYTE, '{CMD_PAYLOAD, 24'hFFFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF},
        8'hFF, 1'b0},
      // third byte closes the packet
      '{TYPED_BYTE, '{CMD_PAYLOAD, 24'h0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b0, 8'hA5},
        8'hA5, 1'b1},
      // one byte too many: dropped
      '{TYPED_NONE, '{CMD_PAYLOAD, 24'h0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b0, 8'h5A},
        8'h00, 1'b0},
      // largest offset, no payload: empty packet, table length ignored
      '{BY_MODEL, '{CMD_HEADER, 24'hFFFFFF, 12'd0, 12'hFFF, 8'hFF, 8'h00, 1'b0, 8'h00},
        8'h00, 1'b0},
      // offset zero with nothing to carry: empty packet with table header
      '{BY_MODEL, '{CMD_HEADER, 24'h0, 12'd0, 12'd0, 8'h2A, 8'h1E, 1'b1, 8'h00},
        8'h00, 1'b0},
      // largest payload, abandoned after one byte
      '{BY_MODEL, '{CMD_HEADER, 24'h000001, 12'hFFF, 12'd0, 8'h50, 8'h3C, 1'b1, 8'h00},
        8'h00, 1'b0},
      '{TYPED_BYTE, '{CMD_PAYLOAD, 24'h0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b0, 8'h5A},
        8'h5A, 1'b0},
      // largest tables, abandoned in turn
      '{BY_MODEL, '{CMD_HEADER, 24'h0, 12'd0, 12'hFFF, 8'h28, 8'h1E, 1'b0, 8'h00},
        8'h00, 1'b0},
      '{TYPED_BYTE, '{CMD_PAYLOAD, 24'h0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b0, 8'h3C},
        8'h3C, 1'b0},
      // single-byte fragment, top offset bit set
      '{BY_MODEL, '{CMD_HEADER, 24'h800000, 12'd1, 12'd0, 8'h01, 8'h01, 1'b0, 8'h00},
        8'h00, 1'b0},
      '{TYPED_BYTE, '{CMD_PAYLOAD, 24'h0, 12'd0, 12'd0, 8'h00, 8'h00, 1'b0, 8'h81},
        8'h81, 1'b1}
   };

   // clock, reset and every input start at a known value
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // framer state as the testbench sees it
   logic [15:0] seq_num;
   logic [31:0] ts_now;
   logic [12:0] bytes_owed;
   logic        pkt_open;
   logic        eof_pending;

   // shadow of the register file
   logic        shadow_tcp;
   logic [31:0] shadow_ssrc;
   logic [31:0] shadow_step;

   // octets still owed by the framer, oldest first
   wire_octet_type octets_due [$];

   // idling percentages of the current phase
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // bookkeeping
   int fail_count     = 0;
   int octets_checked = 0;
   int live_reqs      = 0;
   int header_reqs    = 0;
   int quiet_cycles   = 0;

   rtp_jpeg_packet_framer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // packet finished or abandoned: next sequence number, timestamp moves on at frame end
   function automatic void close_packet();
      seq_num = seq_num + 16'd1;
      if (eof_pending) ts_now = ts_now + shadow_step;
      eof_pending = 1'b0;
      pkt_open    = 1'b0;
      bytes_owed  = '0;
   endfunction

   // octets that one accepted request makes the framer emit
   function automatic void predict_octets(input req_item_type req, input bit queue_them);
      logic [7:0]  hdr [$];
      logic [12:0] body;
      logic [15:0] rtp_len;
      bit          with_tables;
      with_tables = (req.frag_offset == 24'd0);
      if (req.command == CMD_PAYLOAD) begin
         // nothing open: the byte vanishes
         if (!pkt_open) return;
         bytes_owed = bytes_owed - 13'd1;
         if (queue_them) octets_due.push_back('{req.data_byte, bytes_owed == 13'd0});
         if (bytes_owed == 13'd0) close_packet();
         return;
      end
      // a header cuts short whatever is still open
      if (pkt_open) close_packet();
      body    = {1'b0, req.payload_len} + (with_tables ? {1'b0, req.tables_len} : 13'd0);
      rtp_len = 16'd20 + 16'(req.payload_len)
                + (with_tables ? 16'd4 + 16'(req.tables_len) : 16'd0);
      if (shadow_tcp) begin
         hdr.push_back(INTERLEAVE_MAGIC);
         hdr.push_back(8'h00);
         hdr.push_back(rtp_len[15:8]);
         hdr.push_back(rtp_len[7:0]);
      end
      hdr.push_back(RTP_VERSION_BYTE);
      hdr.push_back(RTP_PT_JPEG | (req.end_of_frame ? RTP_MARKER : 8'h00));
      hdr.push_back(seq_num[15:8]);
      hdr.push_back(seq_num[7:0]);
      hdr.push_back(ts_now[31:24]);
      hdr.push_back(ts_now[23:16]);
      hdr.push_back(ts_now[15:8]);
      hdr.push_back(ts_now[7:0]);
      hdr.push_back(shadow_ssrc[31:24]);
      hdr.push_back(shadow_ssrc[23:16]);
      hdr.push_back(shadow_ssrc[15:8]);
      hdr.push_back(shadow_ssrc[7:0]);
      // jpeg main header: type-specific, offset, type, q, width, height
      hdr.push_back(8'h00);
      hdr.push_back(req.frag_offset[23:16]);
      hdr.push_back(req.frag_offset[15:8]);
      hdr.push_back(req.frag_offset[7:0]);
      hdr.push_back(JPEG_TYPE);
      hdr.push_back(JPEG_QUALITY);
      hdr.push_back(req.width_blocks);
      hdr.push_back(req.height_blocks);
      if (with_tables) begin
         hdr.push_back(8'h00);
         hdr.push_back(8'h00);
         hdr.push_back({4'h0, req.tables_len[11:8]});
         hdr.push_back(req.tables_len[7:0]);
      end
      if (queue_them) begin
         foreach (hdr[k])
            octets_due.push_back('{hdr[k], (body == 13'd0) && (k == hdr.size() - 1)});
      end
      eof_pending = req.end_of_frame;
      if (body == 13'd0) begin
         close_packet();
      end else begin
         bytes_owed = body;
         pkt_open   = 1'b1;
      end
   endfunction

   // register write as the framer applies it
   function automatic void shadow_write(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
         CSR_TCP_INTERLEAVE: shadow_tcp  = value[0];
         CSR_SSRC_VALUE:     shadow_ssrc = value;
         CSR_TS_STEP:        shadow_step = value;
         default: ;
      endcase
   endfunction

   // offer one request, with random idle cycles in front, and book it once taken
   task automatic send_req(input req_item_type req, input check_mode_type mode,
                           input logic [7:0] typed_octet, input logic typed_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= req.command;
      req_tlast  <= req.end_of_frame;
      req_tdata  <= {req.data_byte, req.height_blocks, req.width_blocks,
                     req.tables_len, req.payload_len, req.frag_offset};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // dropped payload bytes do not count as real work
      if (req.command == CMD_HEADER || pkt_open) live_reqs++;
      if (req.command == CMD_HEADER) header_reqs++;
      predict_octets(req, mode == BY_MODEL);
      if (mode == TYPED_BYTE) octets_due.push_back('{typed_octet, typed_last});
   endtask

   // one register write; csr_valid stays up so that writes can follow back to back
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_write(idx, value);
   endtask

   // stop offering, wait for every owed octet, then let the framer go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (octets_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new register values and idling pattern for the next phase
   task automatic start_phase(input logic tcp, input logic [31:0] ssrc,
                              input logic [31:0] step, input int send_pct, input int rsp_pct);
      settle();
      write_csr(CSR_TCP_INTERLEAVE, {31'($urandom), tcp});
      write_csr(CSR_SSRC_VALUE, ssrc);
      write_csr(CSR_TS_STEP, step);
      // out-of-range index must leave everything untouched
      write_csr(CSR_UNUSED, $urandom);
      csr_valid     <= 1'b0;
      send_idle_pct = send_pct;
      stall_pct     = rsp_pct;
   endtask

   // one random fragment: mostly a well-formed packet, sometimes cut short or overrun
   task automatic send_fragment();
      req_item_type hdr;
      req_item_type pay;
      int unsigned  body;
      int unsigned  n_bytes;
      int unsigned  roll;
      hdr.command       = CMD_HEADER;
      roll              = $urandom_range(0, 9);
      hdr.frag_offset   = (roll < 4) ? 24'd0 :
                          (roll < 7) ? 24'($urandom_range(1, 4096)) : 24'($urandom);
      hdr.payload_len   = ($urandom_range(0, 19) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(0, 10));
      hdr.tables_len    = ($urandom_range(0, 14) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(0, 6));
      hdr.width_blocks  = 8'($urandom);
      hdr.height_blocks = 8'($urandom);
      hdr.end_of_frame  = 1'($urandom);
      hdr.data_byte     = 8'($urandom);
      body = hdr.payload_len + ((hdr.frag_offset == 24'd0) ? hdr.tables_len : 0);
      roll = $urandom_range(0, 99);
      if (body > 40)
         n_bytes = $urandom_range(0, 6);              // left for the next header to abandon
      else if (roll < 75)
         n_bytes = body;
      else if (roll < 88)
         n_bytes = (body == 0) ? 0 : $urandom_range(0, body - 1);
      else
         n_bytes = body + $urandom_range(1, 3);       // trailing bytes get dropped
      send_req(hdr, BY_MODEL, 8'h00, 1'b0);
      repeat (n_bytes) begin
         // fields other than the data byte are noise for a payload transaction
         pay               = req_item_type'(REQ_DATA_W'({$urandom, $urandom, $urandom}));
         pay.command       = CMD_PAYLOAD;
         send_req(pay, BY_MODEL, 8'h00, 1'b0);
      end
   endtask

   // response side: random back-pressure and the octet-by-octet check
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (octets_due.size() == 0) begin
            $display("%0t: unexpected octet %02h last %0b", $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            if (rsp_tdata !== octets_due[0].octet) begin
               $display("%0t: out_byte expected %02h got %02h",
                        $time, octets_due[0].octet, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== octets_due[0].last) begin
               $display("%0t: packet_last expected %0b got %0b",
                        $time, octets_due[0].last, rsp_tlast);
               fail_count++;
            end
            void'(octets_due.pop_front());
            octets_checked++;
         end
      end
   end

   // watchdog: give up when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d octets still owed",
                  $time, quiet_cycles, octets_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int phase_base;
      // model state and registers after reset
      seq_num     = '0;
      ts_now      = '0;
      bytes_owed  = '0;
      pkt_open    = 1'b0;
      eof_pending = 1'b0;
      shadow_tcp  = 1'b0;
      shadow_ssrc = SSRC_RESET;
      shadow_step = STEP_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset register values, no idling
      for (int r = 0; r < N_DIRECTED; r++)
         send_req(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].mode,
                  DIRECTED_ROWS[r].octet, DIRECTED_ROWS[r].last);

      // random phases: register extremes and random values, each idling pattern
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: start_phase(1'b1, 32'h0000_0000, 32'h0000_0000, 0, 0);
            1: start_phase(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 45, 0);
            2: start_phase(1'b1, $urandom, $urandom, 0, 45);
            default: start_phase(1'b0, $urandom, 32'd1, 8, 8);
         endcase
         phase_base = live_reqs;
         while (live_reqs - phase_base < PHASE_REQS) send_fragment();
      end

      // drain and let any stray octet show up
      settle();

      $display("run covered %0d live requests (%0d headers) and %0d octets checked",
               live_reqs, header_reqs, octets_checked);
      $display("framing in udp and tcp interleave mode, empty, abandoned and overrun packets");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
